[rtl/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and codes of the set-associative LRU cache tag unit.
// ----------------------------------------------------------------------------
`default_nettype none

package salc_pkg;

	// Fixed field widths
	localparam int ADDR_W     = 64;
	localparam int MODE_W     = 2;
	localparam int OUTC_W     = 2;
	localparam int TOTAL_W    = 32;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Access modes; any mode at or above modify makes two accesses
	localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;

	// Outcome codes
	localparam logic [OUTC_W-1:0] OUT_HIT   = 2'd0;
	localparam logic [OUTC_W-1:0] OUT_MISS  = 2'd1;
	localparam logic [OUTC_W-1:0] OUT_EVICT = 2'd2;

	// Register indexes (byte address 4 * index)
	localparam logic [1:0] REG_SET_BITS   = 2'd0;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS       = 2'd2;

	typedef struct packed {
		logic [2:0] set_bits;
		logic [4:0] block_bits;
		logic [3:0] ways;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;  // take the incoming word, work out set and tag
		logic read;     // read the set row
		logic update;   // look up, write the row back, load the result
		logic last;     // result closes the input word
	} cmd_t;

endpackage

`default_nettype wire

[rtl/salc_regs.sv]
// ----------------------------------------------------------------------------
// salc_regs
// Configuration registers behind an APB-style port; flags a line flush on
// every write to a known register.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [salc_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [salc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [salc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready,
	output salc_pkg::cfg_t                        cfg,
	output logic                                  flush
);
	import salc_pkg::*;

	logic [1:0] idx;
	logic       wr;
	logic [2:0] set_bits_q;
	logic [4:0] block_bits_q;
	logic [3:0] ways_q;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite && pready;
	assign flush  = wr && (idx == REG_SET_BITS || idx == REG_BLOCK_BITS || idx == REG_WAYS);

	// Write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 3'd0;
			block_bits_q <= 5'd0;
			ways_q       <= 4'd1;
		end else if (wr) begin
			case (idx)
				REG_SET_BITS:   set_bits_q   <= pwdata[2:0];
				REG_BLOCK_BITS: block_bits_q <= pwdata[4:0];
				REG_WAYS:       ways_q       <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_SET_BITS:   prdata = APB_DATA_W'(set_bits_q);
			REG_BLOCK_BITS: prdata = APB_DATA_W'(block_bits_q);
			REG_WAYS:       prdata = APB_DATA_W'(ways_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.set_bits   = set_bits_q;
	assign cfg.block_bits = block_bits_q;
	assign cfg.ways       = ways_q;

endmodule

`default_nettype wire

[rtl/salc_ctrl.sv]
// ----------------------------------------------------------------------------
// salc_ctrl
// Sequencer: accepts one word, runs one or two set read/update passes and
// owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [salc_pkg::MODE_W-1:0]    s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output salc_pkg::cmd_t                      cmd
);
	import salc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOOKUP
	} state_t;

	state_t state_q;
	logic   second_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	// Decode commands
	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == ST_IDLE) && s_tvalid;
		cmd.read    = (state_q == ST_READ);
		cmd.update  = (state_q == ST_LOOKUP) && out_free;
		cmd.last    = !second_q;
	end

	// Advance state, hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			second_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// raise valid on each update, drop it once the word is taken
			if ((state_q == ST_LOOKUP) && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						second_q <= (s_tuser >= MODE_MODIFY);
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					if (out_free) begin
						if (second_q) begin
							second_q <= 1'b0;
							state_q  <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/salc_dpath.sv]
// ----------------------------------------------------------------------------
// salc_dpath
// Set row memory (tags, LRU ranks, fill count), tag compare and LRU update,
// running totals and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_dpath #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int COUNT_WIDTH  = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire salc_pkg::cfg_t                  cfg,
	input  wire logic                            flush,
	input  wire salc_pkg::cmd_t                  cmd,
	input  wire logic [salc_pkg::ADDR_W-1:0]     address,
	output logic      [salc_pkg::OUTC_W-1:0]     outcome,
	output logic                                 last,
	output logic      [salc_pkg::TOTAL_W-1:0]    hit_total,
	output logic      [salc_pkg::TOTAL_W-1:0]    miss_total,
	output logic      [salc_pkg::TOTAL_W-1:0]    evict_total
);
	import salc_pkg::*;

	localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int FILL_W   = $clog2(MAX_WAYS + 1);

	// Address split
	logic [3:0]              sb;
	logic [5:0]              shamt;
	logic [SET_W-1:0]        set_mask;
	logic [ADDR_W-1:0]       shifted;
	logic [SET_W-1:0]        set_q;
	logic [ADDR_W-1:0]       tag_q;

	// Set memory and its registered read port
	logic [MAX_WAYS-1:0][ADDR_W-1:0] tag_mem  [NUM_SETS];
	logic [MAX_WAYS-1:0][RANK_W-1:0] rank_mem [NUM_SETS];
	logic [FILL_W-1:0]               fill_mem [NUM_SETS];
	logic [NUM_SETS-1:0]             row_vld_q;
	logic [MAX_WAYS-1:0][ADDR_W-1:0] tag_rd_q;
	logic [MAX_WAYS-1:0][RANK_W-1:0] rank_rd_q;
	logic [FILL_W-1:0]               fill_rd_q;
	logic                            rd_ok_q;

	// Lookup
	logic [FILL_W-1:0]               fill;
	logic [FILL_W-1:0]               nw;
	logic                            hit;
	logic                            is_fill;
	logic [RANK_W-1:0]               hit_way;
	logic [RANK_W-1:0]               vic_way;
	logic [RANK_W-1:0]               sel_way;
	logic [RANK_W-1:0]               bound;
	logic [MAX_WAYS-1:0][ADDR_W-1:0] tag_new;
	logic [MAX_WAYS-1:0][RANK_W-1:0] rank_new;
	logic [FILL_W-1:0]               fill_new;
	logic [OUTC_W-1:0]               outcome_c;

	// Totals
	logic [COUNT_WIDTH-1:0] hit_cnt_q;
	logic [COUNT_WIDTH-1:0] miss_cnt_q;
	logic [COUNT_WIDTH-1:0] evict_cnt_q;
	logic [OUTC_W-1:0]      outcome_q;
	logic                   last_q;

	// Split the address into set and tag
	always_comb begin
		sb       = (int'(cfg.set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, cfg.set_bits};
		shamt    = 6'(cfg.block_bits) + 6'(sb);
		set_mask = (SET_W'(1) << sb) - SET_W'(1);
		shifted  = address >> cfg.block_bits;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			set_q <= SET_W'(shifted) & set_mask;
			tag_q <= address >> shamt;
		end
	end

	// Read and write the set row
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			tag_mem[set_q]  <= tag_new;
			rank_mem[set_q] <= rank_new;
			fill_mem[set_q] <= fill_new;
		end
		if (cmd.read) begin
			tag_rd_q  <= tag_mem[set_q];
			rank_rd_q <= rank_mem[set_q];
			fill_rd_q <= fill_mem[set_q];
		end
	end

	// Row valid flags: a row never written since reset or flush reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_ok_q   <= 1'b0;
		end else begin
			if (flush)
				row_vld_q <= '0;
			else if (cmd.update)
				row_vld_q[set_q] <= 1'b1;
			if (cmd.read)
				rd_ok_q <= row_vld_q[set_q];
		end
	end

	// Effective associativity
	always_comb begin
		if (cfg.ways == 4'd0)
			nw = FILL_W'(1);
		else if (int'(cfg.ways) > MAX_WAYS)
			nw = FILL_W'(MAX_WAYS);
		else
			nw = FILL_W'(cfg.ways);
	end

	// Compare tags, pick the way, age the ranks
	always_comb begin
		fill    = rd_ok_q ? fill_rd_q : '0;
		hit     = 1'b0;
		hit_way = '0;
		vic_way = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (i < int'(fill) && tag_rd_q[i] == tag_q) begin
				hit     = 1'b1;
				hit_way = RANK_W'(i);
			end
		end
		// oldest filled way holds rank fill-1
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (i < int'(fill) && rank_rd_q[i] == RANK_W'(fill - FILL_W'(1)))
				vic_way = RANK_W'(i);
		end
		is_fill = !hit && (fill < nw);
		if (hit)
			sel_way = hit_way;
		else if (is_fill)
			sel_way = RANK_W'(fill);
		else
			sel_way = vic_way;
		bound = hit ? rank_rd_q[hit_way] : rank_rd_q[vic_way];

		tag_new  = tag_rd_q;
		rank_new = rank_rd_q;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (i == int'(sel_way))
				rank_new[i] = '0;
			else if (i < int'(fill) && (is_fill || rank_rd_q[i] < bound))
				rank_new[i] = rank_rd_q[i] + RANK_W'(1);
		end
		if (!hit)
			tag_new[sel_way] = tag_q;
		fill_new = is_fill ? fill + FILL_W'(1) : fill;

		if (hit)
			outcome_c = OUT_HIT;
		else if (is_fill)
			outcome_c = OUT_MISS;
		else
			outcome_c = OUT_EVICT;
	end

	// Bump totals, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
		end else if (cmd.update) begin
			if (hit && hit_cnt_q != '1)
				hit_cnt_q <= hit_cnt_q + COUNT_WIDTH'(1);
			if (!hit && miss_cnt_q != '1)
				miss_cnt_q <= miss_cnt_q + COUNT_WIDTH'(1);
			if (!hit && !is_fill && evict_cnt_q != '1)
				evict_cnt_q <= evict_cnt_q + COUNT_WIDTH'(1);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			outcome_q <= outcome_c;
			last_q    <= cmd.last;
		end
	end

	assign outcome     = outcome_q;
	assign last        = last_q;
	assign hit_total   = TOTAL_W'(hit_cnt_q);
	assign miss_total  = TOTAL_W'(miss_cnt_q);
	assign evict_total = TOTAL_W'(evict_cnt_q);

endmodule

`default_nettype wire

[rtl/set_assoc_lru_cache_tags_unit.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_unit
// Set-associative cache tag store with true LRU replacement and totals.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one word per access trace entry, tdata = address, tuser =
//   mode (load, store, modify). A modify gives two result words.
//   Output stream: one word per access, tuser = outcome (hit, miss, miss with
//   eviction), tlast on the final word of an input word, tdata = running hit,
//   miss and eviction totals.
//   APB port: set_bits, block_bits and ways; a write to any of them flushes
//   every line and keeps the totals.
// Timing:
//   Each access is a read and a write-back of one set row in the set memory:
//   the input word is taken into the set and tag registers, the set row is
//   read into the row registers, then the lookup writes the row back and
//   loads the result register. A modify makes two such passes.
//   A result waiting on a stalled receiver does not block the next input
//   word; the following lookup waits until the result register is free.
// Reset:
//   All lines empty (per-set valid flags, no clearing pass), totals zero,
//   set_bits 0, block_bits 0, ways 1.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_tags_unit #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int COUNT_WIDTH  = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [salc_pkg::ADDR_W-1:0]       s_tdata,  // address
	input  wire logic [salc_pkg::MODE_W-1:0]       s_tuser,  // mode
	// output stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [3*salc_pkg::TOTAL_W-1:0]         m_tdata,  // hit_total, miss_total, evict_total
	output logic [salc_pkg::OUTC_W-1:0]            m_tuser,  // outcome
	output logic                                   m_tlast,
	// configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [salc_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [salc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [salc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready
);
	import salc_pkg::*;

	cfg_t              cfg;
	cmd_t              cmd;
	logic              flush;
	logic [TOTAL_W-1:0] hit_total;
	logic [TOTAL_W-1:0] miss_total;
	logic [TOTAL_W-1:0] evict_total;

	salc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.flush   (flush)
	);

	salc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	salc_dpath #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.flush       (flush),
		.cmd         (cmd),
		.address     (s_tdata),
		.outcome     (m_tuser),
		.last        (m_tlast),
		.hit_total   (hit_total),
		.miss_total  (miss_total),
		.evict_total (evict_total)
	);

	assign m_tdata = {evict_total, miss_total, hit_total};

endmodule

`default_nettype wire

[rtl/salc_checker.sv]
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks of the cache tag unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  s_tvalid,
	input wire logic                                  s_tready,
	input wire logic                                  m_tvalid,
	input wire logic                                  m_tready,
	input wire logic [3*salc_pkg::TOTAL_W-1:0]        m_tdata,
	input wire logic [salc_pkg::OUTC_W-1:0]           m_tuser
);
	import salc_pkg::*;

	// A stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its totals
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result totals changed while stalled");

	// One input word at a time: ready drops after a word is taken
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an access is in progress");

	// Only three outcome codes exist
	a_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == OUT_HIT || m_tuser == OUT_MISS || m_tuser == OUT_EVICT))
		else $error("bad outcome code");

	// An eviction is always counted
	a_evict_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == OUT_EVICT |-> m_tdata[3*TOTAL_W-1:2*TOTAL_W] != '0)
		else $error("eviction reported with zero eviction total");

endmodule

bind set_assoc_lru_cache_tags_unit salc_checker u_salc_checker (.*);

`default_nettype wire
